/* rtl/assert_macros.svh */
// Assertion helpers for the rotation pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/qvr_pkg.sv */
`timescale 1ns / 1ps
package qvr_pkg;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_w;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               zero_quat;
    logic               overflowed;
  } out_t;

  // Hamilton product term signs, bit [4*component + term] set means subtract
  localparam logic [15:0] HAM_NEG = 16'h428E;

  // second operand index of term i in component c
  function automatic logic [1:0] ham_b(input logic [1:0] c, input logic [1:0] i);
    return c ^ i;
  endfunction

endpackage

/* rtl/quaternion_vector_rotation.sv */
`timescale 1ns / 1ps
// Rotates a Q-format vector by a quaternion, v' = q * v * q^-1, one transaction per clock.
// The block never stalls: busy stays low and a transaction can be started every cycle.
// Each result appears on out_data with out_valid high for one cycle; the receiver must
// take it then. The pipeline is the inverse-norm divider, which retires one quotient
// bit per stage over 32 + FRAC_BITS stages, plus two multiply and three sum/saturate
// stages.
module quaternion_vector_rotation #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  qvr_pkg::in_t  in_data,
  output logic          out_valid,
  output qvr_pkg::out_t out_data
);

  `include "assert_macros.svh"

  localparam int QW  = 32 + FRAC_BITS;
  localparam int NW  = 65 - FRAC_BITS;
  localparam int LAT = QW + 5;
  localparam logic signed [66:0] SAT_HI = (67'sd1 <<< (DATA_WIDTH - 1)) - 67'sd1;
  localparam logic signed [66:0] SAT_LO = -SAT_HI - 67'sd1;

  typedef struct packed {
    logic                      vld;
    logic                      zq;
    logic                      ovf;
    logic [3:0]                neg;
    logic [3:0][31:0]          t;
    logic [NW-1:0]             n;
    logic [3:0][NW-1:0]        rem;
    logic [3:0][QW-1:0]        quo;
  } dstg_t;

  function automatic logic [32:0] sat_dw(input logic signed [66:0] v);
    if (v > SAT_HI) return {1'b1, SAT_HI[31:0]};
    if (v < SAT_LO) return {1'b1, SAT_LO[31:0]};
    return {1'b0, v[31:0]};
  endfunction

  function automatic dstg_t div_step(input dstg_t a);
    dstg_t      o;
    logic [NW:0] sh;
    o = a;
    for (int l = 0; l < 4; l++) begin
      sh = {a.rem[l], a.quo[l][QW-1]};
      if (sh >= {1'b0, a.n}) begin
        o.rem[l] = NW'(sh - {1'b0, a.n});
        o.quo[l] = {a.quo[l][QW-2:0], 1'b1};
      end else begin
        o.rem[l] = sh[NW-1:0];
        o.quo[l] = {a.quo[l][QW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic signed [31:0] qa [4];
  logic signed [31:0] va [4];
  logic [31:0]        mag [4];
  logic [3:0]         neg;
  logic               acc;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_comb begin
    qa[0] = in_data.quat_w;
    qa[1] = in_data.quat_x;
    qa[2] = in_data.quat_y;
    qa[3] = in_data.quat_z;
    va[0] = '0;
    va[1] = in_data.vec_x;
    va[2] = in_data.vec_y;
    va[3] = in_data.vec_z;
    for (int i = 0; i < 4; i++) begin
      mag[i] = qa[i][31] ? 32'(-qa[i]) : 32'(qa[i]);
    end
    neg[0] = qa[0][31];
    for (int i = 1; i < 4; i++) begin
      neg[i] = ~qa[i][31] && (qa[i] != 32'sd0);
    end
  end

  // stage 0: squares and first product terms
  logic               s0_vld_r;
  logic signed [63:0] p1_r [4][4];
  logic [63:0]        sq_r [4];
  logic [31:0]        mag_r [4];
  logic [3:0]         neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= acc;
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        p1_r[c][i] <= qa[i] * va[qvr_pkg::ham_b(2'(c), 2'(i))];
      end
      sq_r[c]  <= mag[c] * mag[c];
      mag_r[c] <= mag[c];
    end
    neg_r <= neg;
  end

  // stage 1: norm and q*v
  logic [64:0]        sq_sum;
  logic signed [66:0] hsum1 [4];
  logic [32:0]        sat1 [4];
  dstg_t              d0_nxt;

  always_comb begin
    sq_sum = 65'(sq_r[0]) + 65'(sq_r[1]) + 65'(sq_r[2]) + 65'(sq_r[3]);
    d0_nxt     = '0;
    d0_nxt.vld = s0_vld_r;
    d0_nxt.n   = sq_sum[64:FRAC_BITS];
    d0_nxt.zq  = (sq_sum[64:FRAC_BITS] == '0);
    d0_nxt.neg = neg_r;
    for (int c = 0; c < 4; c++) begin
      hsum1[c] = '0;
      for (int i = 0; i < 4; i++) begin
        if (qvr_pkg::HAM_NEG[4*c+i]) hsum1[c] = hsum1[c] - 67'(p1_r[c][i]);
        else                         hsum1[c] = hsum1[c] + 67'(p1_r[c][i]);
      end
      sat1[c]        = sat_dw(hsum1[c] >>> FRAC_BITS);
      d0_nxt.t[c]    = sat1[c][31:0];
      d0_nxt.ovf     = d0_nxt.ovf | sat1[c][32];
      d0_nxt.quo[c]  = {mag_r[c], {FRAC_BITS{1'b0}}};
    end
  end

  dstg_t dp_r [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r[0] <= '0;
    end else begin
      dp_r[0] <= d0_nxt;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dp_r[k+1] <= '0;
      end else begin
        dp_r[k+1] <= div_step(dp_r[k]);
      end
    end
  end

  // inverse components
  logic               e_vld_r, e_zq_r, e_ovf_r;
  logic signed [31:0] inv_r [4];
  logic signed [31:0] t_r [4];
  logic [32:0]        sat_e [4];
  logic               ovf_e;

  always_comb begin
    ovf_e = dp_r[QW].ovf;
    for (int l = 0; l < 4; l++) begin
      sat_e[l] = sat_dw(dp_r[QW].neg[l] ? -$signed(67'(dp_r[QW].quo[l]))
                                        :  $signed(67'(dp_r[QW].quo[l])));
      ovf_e = ovf_e | sat_e[l][32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= dp_r[QW].vld;
    end
    e_zq_r  <= dp_r[QW].zq;
    e_ovf_r <= ovf_e;
    for (int l = 0; l < 4; l++) begin
      inv_r[l] <= sat_e[l][31:0];
      t_r[l]   <= dp_r[QW].t[l];
    end
  end

  // t * q^-1 product terms
  logic               m_vld_r, m_zq_r, m_ovf_r;
  logic signed [63:0] p2_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= e_vld_r;
    end
    m_zq_r  <= e_zq_r;
    m_ovf_r <= e_ovf_r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        p2_r[c][i] <= t_r[i] * inv_r[qvr_pkg::ham_b(2'(c), 2'(i))];
      end
    end
  end

  // final sums and saturation
  logic signed [66:0] hsum2 [4];
  logic [32:0]        sat2 [4];
  logic               ovf_o;
  qvr_pkg::out_t      out_nxt;
  logic               out_valid_r;
  qvr_pkg::out_t      out_r;

  always_comb begin
    ovf_o = m_ovf_r;
    for (int c = 0; c < 4; c++) begin
      hsum2[c] = '0;
      for (int i = 0; i < 4; i++) begin
        if (qvr_pkg::HAM_NEG[4*c+i]) hsum2[c] = hsum2[c] - 67'(p2_r[c][i]);
        else                         hsum2[c] = hsum2[c] + 67'(p2_r[c][i]);
      end
      sat2[c] = sat_dw(hsum2[c] >>> FRAC_BITS);
      ovf_o   = ovf_o | sat2[c][32];
    end
    if (m_zq_r) begin
      out_nxt           = '0;
      out_nxt.zero_quat = 1'b1;
    end else begin
      out_nxt.out_w      = sat2[0][31:0];
      out_nxt.out_x      = sat2[1][31:0];
      out_nxt.out_y      = sat2[2][31:0];
      out_nxt.out_z      = sat2[3][31:0];
      out_nxt.zero_quat  = 1'b0;
      out_nxt.overflowed = ovf_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m_vld_r;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic zq_clean;
  assign zq_clean = !out_r.overflowed && out_r.out_x == 32'sd0 && out_r.out_w == 32'sd0;

  `ASSERT_RST(a_latency, clk, rst_n, acc |-> ##LAT out_valid_r)
  `ASSERT_RST(a_div_to_out, clk, rst_n, dp_r[QW].vld |-> ##3 out_valid_r)
  `ASSERT_RST(a_zero_quat, clk, rst_n, out_valid_r && out_r.zero_quat |-> zq_clean)
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid_r)

endmodule
